@@ sv/lmbp_pkg.sv @@
// Shared types and constants for the bit-plane LED matrix refresh engine.
// No dependencies; the front, queue, back and top-level files import this package.
package lmbp_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PERIOD_P0 = 2'd0;
    localparam logic [1:0] CFG_PERIOD_P1 = 2'd1;
    localparam logic [1:0] CFG_PERIOD_P2 = 2'd2;
    localparam logic [1:0] CFG_FIRST_INT = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [7:0] PERIOD_P0_RST = 8'd60;
    localparam logic [7:0] PERIOD_P1_RST = 8'd120;
    localparam logic [7:0] PERIOD_P2_RST = 8'd160;
    localparam logic [7:0] FIRST_INT_RST = 8'h30;

    // Item function codes.
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    localparam logic [7:0] CLOCK_MASK_TOP = 8'h80;

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef struct packed {
        logic       refresh;   // 1: refresh a plane, 0: store one frame byte
        logic [2:0] plane;
        logic [2:0] row;
        logic [2:0] byte_idx;
        logic [7:0] data;
    } cmd_t;

    typedef struct packed {
        logic clearing;        // frame store clear pass after reset in progress
    } status_t;

endpackage

@@ sv/lmbp_if.sv @@
// Channel interfaces of the refresh engine: input items, result rows and
// configuration writes. No dependencies.
interface lmbp_item_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [2:0] plane_index;
    logic [2:0] row_index;
    logic [2:0] byte_index;
    logic [7:0] byte_value;

    modport source (output valid, func, plane_index, row_index, byte_index, byte_value,
                    input ready);
    modport sink (input valid, func, plane_index, row_index, byte_index, byte_value,
                  output ready);
endinterface

interface lmbp_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  row_number;
    logic [7:0]  clock_mask;
    logic [2:0]  shown_plane;
    logic [63:0] shift_bits;
    logic        last_row;

    modport source (output valid, row_number, clock_mask, shown_plane, shift_bits,
                    last_row, input ready);
    modport sink (input valid, row_number, clock_mask, shown_plane, shift_bits,
                  last_row, output ready);
endinterface

interface lmbp_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ sv/lmbp_front.sv @@
// Front end: accepts items and configuration writes, runs the tick counter
// and plane sequence, and queues frame writes and refresh commands. Uses lmbp_pkg.
module lmbp_front
    import lmbp_pkg::*;
#(
    parameter int NUM_PLANES = 3
) (
    input  logic       clk,
    input  logic       rst_n,
    lmbp_item_if.sink  item,
    lmbp_cfg_if.sink   cfg,
    input  status_t    status,
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_data
);

    localparam logic [2:0] PLANE_LAST = 3'(NUM_PLANES - 1);

    logic [7:0] period_p0_reg;
    logic [7:0] period_p1_reg;
    logic [7:0] period_p2_reg;
    logic [7:0] tick_count_reg;
    logic [7:0] compare_reg;
    logic [2:0] plane_reg;

    logic [7:0] compare_next;
    logic       accept;
    logic       match;

    assign item.ready = !status.clearing && !q_full;
    assign cfg.ready  = 1'b1;
    assign accept     = item.valid && item.ready;
    assign match      = (tick_count_reg == compare_reg);

    // Period loaded when the current plane is shown; higher planes keep it.
    always_comb
    begin
        unique case (plane_reg)
            3'd0:    compare_next = period_p0_reg;
            3'd1:    compare_next = period_p1_reg;
            3'd2:    compare_next = period_p2_reg;
            default: compare_next = compare_reg;
        endcase
    end

    always_comb
    begin
        q_data.refresh  = (item.func == FUNC_TICK);
        q_data.plane    = (item.func == FUNC_TICK) ? plane_reg : item.plane_index;
        q_data.row      = item.row_index;
        q_data.byte_idx = item.byte_index;
        q_data.data     = item.byte_value;
        q_push          = 1'b0;
        if (accept)
        begin
            if (item.func == FUNC_TICK)
                q_push = match;
            else
                q_push = (4'(item.plane_index) < 4'(NUM_PLANES));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_p0_reg  <= PERIOD_P0_RST;
            period_p1_reg  <= PERIOD_P1_RST;
            period_p2_reg  <= PERIOD_P2_RST;
            tick_count_reg <= 8'd0;
            compare_reg    <= FIRST_INT_RST;
            plane_reg      <= 3'd0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    CFG_PERIOD_P0: period_p0_reg <= cfg.data;
                    CFG_PERIOD_P1: period_p1_reg <= cfg.data;
                    CFG_PERIOD_P2: period_p2_reg <= cfg.data;
                    // The first interval only matters through the compare value.
                    CFG_FIRST_INT: compare_reg   <= cfg.data;
                    default: ;
                endcase
            end
            if (accept && item.func == FUNC_TICK)
            begin
                if (match)
                begin
                    tick_count_reg <= 8'd0;
                    compare_reg    <= compare_next;
                    plane_reg      <= (plane_reg == PLANE_LAST) ? 3'd0 : plane_reg + 3'd1;
                end
                else
                begin
                    tick_count_reg <= tick_count_reg + 8'd1;
                end
            end
        end
    end

`ifndef ASSERT_OFF
    // No item may enter while the frame store is still being cleared.
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        status.clearing |-> !accept)
        else $error("item accepted during frame store clear");
    // The plane sequence never leaves the stored planes.
    a_plane_range: assert property (@(posedge clk) disable iff (!rst_n)
        q_push && q_data.refresh |-> (4'(q_data.plane) < 4'(NUM_PLANES)))
        else $error("refresh queued for a plane that is not stored");
`endif

endmodule

@@ sv/lmbp_queue.sv @@
// Short command queue that decouples the front end from the refresh back end.
// Uses cmd_t and queue constants from lmbp_pkg.
module lmbp_queue
    import lmbp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output cmd_t head,
    output logic empty
);

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;

    assign full  = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("command queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("command queue underflow");
`endif

endmodule

@@ sv/lmbp_back.sv @@
// Back end: owns the frame store, clears it after reset, applies byte writes
// and reads a plane row by row into the result register. Uses lmbp_pkg.
module lmbp_back
    import lmbp_pkg::*;
#(
    parameter int NUM_PLANES    = 3,
    parameter int NUM_ROWS_USED = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  cmd_t          head,
    input  logic          empty,
    output logic          pop,
    output status_t       status,
    lmbp_result_if.source result
);

    localparam int         MEM_DEPTH = NUM_PLANES * 64;
    localparam int         AW        = $clog2(MEM_DEPTH);
    localparam logic [AW-1:0] ADDR_LAST = AW'(MEM_DEPTH - 1);
    localparam logic [2:0] ROW_LAST  = 3'(NUM_ROWS_USED - 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_PUSH  = 3'd4;

    logic [7:0]    mem [MEM_DEPTH];

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [AW-1:0] clr_cnt_reg;
    logic [2:0]    plane_reg;
    logic [2:0]    row_reg;
    logic [2:0]    byte_reg;
    logic          rd_valid_reg;
    logic [7:0]    rd_data_reg;
    logic [63:0]   acc_reg;

    logic          out_valid_reg;
    logic [2:0]    row_number_reg;
    logic [7:0]    clock_mask_reg;
    logic [2:0]    shown_plane_reg;
    logic [63:0]   shift_bits_reg;
    logic          last_row_reg;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          load_out;

    assign status.clearing = (state_reg == ST_CLEAR);
    assign rd_en    = (state_reg == ST_READ);
    assign rd_addr  = AW'({plane_reg, row_reg, byte_reg});
    assign load_out = (state_reg == ST_PUSH) && (!out_valid_reg || result.ready);

    assign result.valid       = out_valid_reg;
    assign result.row_number  = row_number_reg;
    assign result.clock_mask  = clock_mask_reg;
    assign result.shown_plane = shown_plane_reg;
    assign result.shift_bits  = shift_bits_reg;
    assign result.last_row    = last_row_reg;

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = AW'({head.plane, head.row, head.byte_idx});
        mem_wdata  = head.data;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = 8'd0;
                if (clr_cnt_reg == ADDR_LAST)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop = 1'b1;
                    if (head.refresh)
                        state_next = ST_READ;
                    else
                        mem_we = 1'b1;
                end
            end
            ST_READ:
            begin
                if (byte_reg == 3'd0)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (load_out)
                    state_next = (row_reg == ROW_LAST) ? ST_IDLE : ST_READ;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Frame store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // Bytes arrive from byte 7 down to byte 0, so byte 7 ends up on top.
    always_ff @(posedge clk)
    begin
        if (rd_valid_reg)
            acc_reg <= {acc_reg[55:0], rd_data_reg};
        if (load_out)
        begin
            row_number_reg  <= row_reg;
            clock_mask_reg  <= CLOCK_MASK_TOP >> row_reg;
            shown_plane_reg <= plane_reg;
            shift_bits_reg  <= ~acc_reg;
            last_row_reg    <= (row_reg == ROW_LAST);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            plane_reg     <= 3'd0;
            row_reg       <= 3'd0;
            byte_reg      <= 3'd7;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_en;
            if (state_reg == ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (state_reg == ST_IDLE && !empty && head.refresh)
            begin
                plane_reg <= head.plane;
                row_reg   <= 3'd0;
                byte_reg  <= 3'd7;
            end
            if (rd_en)
                byte_reg <= byte_reg - 3'd1;
            if (load_out)
            begin
                row_reg  <= row_reg + 3'd1;
                byte_reg <= 3'd7;
            end
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

`ifndef ASSERT_OFF
    a_mask_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $onehot(clock_mask_reg))
        else $error("clock mask of a result is not one-hot");
`endif

endmodule

@@ sv/led_matrix_bit_plane_refresh.sv @@
// Bit-plane LED matrix refresh engine, top level.
// Channels: item (frame byte writes and prescaled timer ticks), result (one
// row of shift data per transfer) and cfg (period and first-interval
// registers, always ready). All use valid/ready; a transfer happens when both
// are high at a rising edge of clk.
// A write item is stored by the back end as it is popped; a tick without compare
// match finishes in the front end and yields nothing.
// A matching tick starts a refresh of NUM_ROWS_USED rows. Each row reads its
// eight frame bytes from the single read port of the frame store (ST_READ),
// then passes ST_DRAIN and ST_PUSH, where it is loaded into the result
// register once that register is free or being read.
// A four-entry command queue lets the front accept items while a refresh
// runs; item.ready drops when that queue is full or while the store is cleared.
// After reset the frame store is cleared, one byte a cycle, all
// NUM_PLANES * 64 bytes; items are not taken meanwhile, configuration is.
// When the receiver stalls, the result register holds, then the back end and
// finally the queue and the item channel stall.
module led_matrix_bit_plane_refresh
    import lmbp_pkg::*;
#(
    parameter int NUM_PLANES    = 3,
    parameter int NUM_ROWS_USED = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    lmbp_item_if.sink     item,
    lmbp_result_if.source result,
    lmbp_cfg_if.sink      cfg
);

    status_t status;
    logic    q_full;
    logic    q_push;
    cmd_t    q_data;
    logic    q_pop;
    cmd_t    q_head;
    logic    q_empty;

    lmbp_front #(
        .NUM_PLANES (NUM_PLANES)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cfg    (cfg),
        .status (status),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_data)
    );

    lmbp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    lmbp_back #(
        .NUM_PLANES    (NUM_PLANES),
        .NUM_ROWS_USED (NUM_ROWS_USED)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (q_head),
        .empty  (q_empty),
        .pop    (q_pop),
        .status (status),
        .result (result)
    );

endmodule
